/* src/nnis_pkg.sv */
// ----------------------------------------------------------------------------
// nnis_pkg
// shared constants and types of the nearest neighbor image scaler
// ----------------------------------------------------------------------------
package nnis_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_DST_DIM    = 4096;
  localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);

  localparam int SW_W   = 9;
  localparam int DW_W   = 13;
  localparam int COORD_W = 12;
  localparam int PIX_W  = 24;
  localparam int Q_BITS = 8;
  localparam int NUM_W  = COORD_W + SW_W;

  localparam int MIDQ_DEPTH = 4;
  localparam int MIDQ_AW    = $clog2(MIDQ_DEPTH);
  localparam int OUTQ_DEPTH = 16;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

  typedef struct packed {
    logic [SW_W-1:0] sw;
    logic [SW_W-1:0] sh;
    logic [DW_W-1:0] dw;
    logic [DW_W-1:0] dh;
  } dims_t;

  typedef struct packed {
    logic              is_fetch;
    logic              oor;
    logic              load_ok;
    logic [ADDR_W-1:0] idx;
    logic [PIX_W-1:0]  pixel;
    logic [NUM_W-1:0]  ncol;
    logic [NUM_W-1:0]  nrow;
  } qitem_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [Q_BITS-1:0] col;
    logic [Q_BITS-1:0] row;
    logic              oor;
  } result_t;

endpackage

/* src/nnis_ram.sv */
// ----------------------------------------------------------------------------
// nnis_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module nnis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/nnis_front.sv */
// ----------------------------------------------------------------------------
// nnis_front
// limits the sizes and classifies an incoming item
// ----------------------------------------------------------------------------
module nnis_front import nnis_pkg::*; (
  input  logic [SW_W-1:0]    src_width,
  input  logic [SW_W-1:0]    src_height,
  input  logic [DW_W-1:0]    dst_width,
  input  logic [DW_W-1:0]    dst_height,
  input  logic               req_type,
  input  logic [ADDR_W-1:0]  src_index,
  input  logic [7:0]         pixel_red,
  input  logic [7:0]         pixel_green,
  input  logic [7:0]         pixel_blue,
  input  logic [COORD_W-1:0] dst_x,
  input  logic [COORD_W-1:0] dst_y,
  output dims_t              dims,
  output qitem_t             item
);

  function automatic logic [SW_W-1:0] lim_src(input logic [SW_W-1:0] v,
                                              input logic [SW_W-1:0] mx);
    if (v == '0) return SW_W'(1);
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic logic [DW_W-1:0] lim_dst(input logic [DW_W-1:0] v);
    if (v == '0) return DW_W'(1);
    if (v > DW_W'(MAX_DST_DIM)) return DW_W'(MAX_DST_DIM);
    return v;
  endfunction

  logic [2*SW_W-1:0] area;

  always_comb begin
    dims.sw = lim_src(src_width, SW_W'(MAX_SRC_WIDTH));
    dims.sh = lim_src(src_height, SW_W'(MAX_SRC_HEIGHT));
    dims.dw = lim_dst(dst_width);
    dims.dh = lim_dst(dst_height);
    area    = dims.sw * dims.sh;

    item.is_fetch = req_type;
    item.oor      = ({1'b0, dst_x} >= dims.dw) || ({1'b0, dst_y} >= dims.dh);
    item.load_ok  = ((2*SW_W)'(src_index) < area);
    item.idx      = src_index;
    item.pixel    = {pixel_red, pixel_green, pixel_blue};
    item.ncol     = NUM_W'(dst_x) * NUM_W'(dims.sw);
    item.nrow     = NUM_W'(dst_y) * NUM_W'(dims.sh);
  end

endmodule

/* src/nnis_midq.sv */
// ----------------------------------------------------------------------------
// nnis_midq
// short queue between the front and the back
// ----------------------------------------------------------------------------
module nnis_midq import nnis_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  qitem_t wr_item,
  output logic   full,
  input  logic   rd,
  output qitem_t head,
  output logic   empty
);

  qitem_t             slots [MIDQ_DEPTH];
  logic [MIDQ_AW-1:0] wptr;
  logic [MIDQ_AW-1:0] rptr;
  logic [MIDQ_AW:0]   count;

  assign full  = (count == (MIDQ_AW+1)'(MIDQ_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (MIDQ_AW+1)'(wr) - (MIDQ_AW+1)'(rd);
    end
    if (wr) begin
      slots[wptr] <= wr_item;
    end
  end

endmodule

/* src/nnis_back.sv */
// ----------------------------------------------------------------------------
// nnis_back
// divider pipeline, address stage, frame store and result queue
// ----------------------------------------------------------------------------
module nnis_back import nnis_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  dims_t   dims,
  input  qitem_t  head,
  input  logic    mq_empty,
  output logic    mq_pop,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  typedef struct packed {
    logic              valid;
    logic              is_fetch;
    logic              oor;
    logic              load_ok;
    logic [ADDR_W-1:0] idx;
    logic [PIX_W-1:0]  pixel;
    logic [NUM_W-1:0]  rcol;
    logic [NUM_W-1:0]  rrow;
    logic [Q_BITS-1:0] qcol;
    logic [Q_BITS-1:0] qrow;
  } div_t;

  typedef struct packed {
    logic              valid;
    logic              oor;
    logic [Q_BITS-1:0] col;
    logic [Q_BITS-1:0] row;
  } rd_t;

  div_t              dv [Q_BITS+1];
  div_t              dv_next [Q_BITS];
  logic              ma_valid;
  logic              ma_fetch;
  logic              ma_we;
  logic              ma_oor;
  logic [ADDR_W-1:0] ma_addr;
  logic [PIX_W-1:0]  ma_pixel;
  logic [Q_BITS-1:0] ma_col;
  logic [Q_BITS-1:0] ma_row;
  rd_t               rs;
  logic [PIX_W-1:0]  rdata;
  logic [OUTQ_AW:0]  reserved;
  logic              oq_push;
  result_t           oq_data;
  result_t           oq [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] oq_wptr;
  logic [OUTQ_AW-1:0] oq_rptr;
  logic [OUTQ_AW:0]  oq_count;
  logic              out_pop;
  logic [2*SW_W-1:0] addr_full;

  // a fetch may leave the queue only with a free result slot reserved
  assign mq_pop  = !mq_empty &&
                   (!head.is_fetch || (reserved != (OUTQ_AW+1)'(OUTQ_DEPTH)));
  assign out_pop = pop && !empty;

  // one restoring division step per stage, both axes side by side
  always_comb begin
    for (int k = 0; k < Q_BITS; k++) begin
      logic [NUM_W-1:0] dc;
      logic [NUM_W-1:0] dr;
      dc = NUM_W'(dims.dw) << (Q_BITS-1-k);
      dr = NUM_W'(dims.dh) << (Q_BITS-1-k);
      dv_next[k] = dv[k];
      if (dv[k].rcol >= dc) begin
        dv_next[k].rcol = dv[k].rcol - dc;
        dv_next[k].qcol[Q_BITS-1-k] = 1'b1;
      end
      if (dv[k].rrow >= dr) begin
        dv_next[k].rrow = dv[k].rrow - dr;
        dv_next[k].qrow[Q_BITS-1-k] = 1'b1;
      end
    end
  end

  assign addr_full = (2*SW_W)'(dv[Q_BITS].qrow) * (2*SW_W)'(dims.sw)
                   + (2*SW_W)'(dv[Q_BITS].qcol);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= Q_BITS; k++) begin
        dv[k].valid <= 1'b0;
      end
      ma_valid <= 1'b0;
      ma_we    <= 1'b0;
      rs.valid <= 1'b0;
    end else begin
      dv[0].valid <= mq_pop;
      for (int k = 0; k < Q_BITS; k++) begin
        dv[k+1].valid <= dv[k].valid;
      end
      ma_valid <= dv[Q_BITS].valid;
      ma_we    <= dv[Q_BITS].valid && !dv[Q_BITS].is_fetch && dv[Q_BITS].load_ok;
      rs.valid <= ma_valid && ma_fetch;
    end
    dv[0].is_fetch <= head.is_fetch;
    dv[0].oor      <= head.oor;
    dv[0].load_ok  <= head.load_ok;
    dv[0].idx      <= head.idx;
    dv[0].pixel    <= head.pixel;
    dv[0].rcol     <= head.ncol;
    dv[0].rrow     <= head.nrow;
    dv[0].qcol     <= '0;
    dv[0].qrow     <= '0;
    for (int k = 0; k < Q_BITS; k++) begin
      dv[k+1].is_fetch <= dv_next[k].is_fetch;
      dv[k+1].oor      <= dv_next[k].oor;
      dv[k+1].load_ok  <= dv_next[k].load_ok;
      dv[k+1].idx      <= dv_next[k].idx;
      dv[k+1].pixel    <= dv_next[k].pixel;
      dv[k+1].rcol     <= dv_next[k].rcol;
      dv[k+1].rrow     <= dv_next[k].rrow;
      dv[k+1].qcol     <= dv_next[k].qcol;
      dv[k+1].qrow     <= dv_next[k].qrow;
    end
    ma_fetch <= dv[Q_BITS].is_fetch;
    ma_oor   <= dv[Q_BITS].oor;
    ma_pixel <= dv[Q_BITS].pixel;
    ma_col   <= dv[Q_BITS].qcol;
    ma_row   <= dv[Q_BITS].qrow;
    ma_addr  <= dv[Q_BITS].is_fetch ? addr_full[ADDR_W-1:0] : dv[Q_BITS].idx;
    rs.oor   <= ma_oor;
    rs.col   <= ma_col;
    rs.row   <= ma_row;
  end

  nnis_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ma_valid && ma_we),
    .addr (ma_addr),
    .wdata(ma_pixel),
    .rdata(rdata)
  );

  // result queue
  assign oq_push = rs.valid;
  always_comb begin
    oq_data = '0;
    oq_data.oor = rs.oor;
    if (!rs.oor) begin
      oq_data.pixel = rdata;
      oq_data.col   = rs.col;
      oq_data.row   = rs.row;
    end
  end

  assign empty  = (oq_count == '0);
  assign result = oq[oq_rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wptr  <= '0;
      oq_rptr  <= '0;
      oq_count <= '0;
      reserved <= '0;
    end else begin
      if (oq_push) begin
        oq_wptr <= oq_wptr + 1'b1;
      end
      if (out_pop) begin
        oq_rptr <= oq_rptr + 1'b1;
      end
      oq_count <= oq_count + (OUTQ_AW+1)'(oq_push) - (OUTQ_AW+1)'(out_pop);
      reserved <= reserved + (OUTQ_AW+1)'(mq_pop && head.is_fetch)
                - (OUTQ_AW+1)'(out_pop);
    end
    if (oq_push) begin
      oq[oq_wptr] <= oq_data;
    end
  end

endmodule

/* src/nearest_neighbor_image_scaler.sv */
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// frame store with nearest neighbor lookup of scaled pixels
// ----------------------------------------------------------------------------
// the block takes one item per clock while full is low, loads and fetches
// mixed in any order, and returns one result per fetch in order. a load
// writes an in-range source pixel into a 64k x 24 frame store; a fetch maps
// (dst_x, dst_y) onto the source grid with two 8-stage restoring dividers,
// forms the row-major address and reads the store. throughput is one item
// per cycle as long as results are popped, set by the 16-entry result queue
// whose slots are reserved when a fetch enters the divider pipeline. loads
// and fetches reach the store in the same pipeline stage, so a fetch always
// sees every earlier load. sizes are to be written over the apb port only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler import nnis_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // item input
  input  logic               push,
  output logic               full,
  input  logic               req_type,
  input  logic [15:0]        src_index,
  input  logic [7:0]         pixel_red,
  input  logic [7:0]         pixel_green,
  input  logic [7:0]         pixel_blue,
  input  logic [11:0]        dst_x,
  input  logic [11:0]        dst_y,
  // result output
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         src_col,
  output logic [7:0]         src_row,
  output logic               out_of_range
);

  logic [SW_W-1:0] src_width;
  logic [SW_W-1:0] src_height;
  logic [DW_W-1:0] dst_width;
  logic [DW_W-1:0] dst_height;
  logic [1:0]      reg_sel;
  dims_t           dims;
  qitem_t          item;
  qitem_t          head;
  logic            mq_empty;
  logic            mq_pop;
  result_t         result;

  // register file, keeps the low 9 or 13 written bits as they are
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SW_W'(256);
      src_height <= SW_W'(256);
      dst_width  <= DW_W'(256);
      dst_height <= DW_W'(256);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_SRC_WIDTH:  src_width  <= pwdata[SW_W-1:0];
        REG_SRC_HEIGHT: src_height <= pwdata[SW_W-1:0];
        REG_DST_WIDTH:  dst_width  <= pwdata[DW_W-1:0];
        REG_DST_HEIGHT: dst_height <= pwdata[DW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SRC_WIDTH:  prdata = 32'(src_width);
      REG_SRC_HEIGHT: prdata = 32'(src_height);
      REG_DST_WIDTH:  prdata = 32'(dst_width);
      REG_DST_HEIGHT: prdata = 32'(dst_height);
      default:        prdata = '0;
    endcase
  end

  // front: size limiting, range check, products for the dividers
  nnis_front u_front (
    .src_width  (src_width),
    .src_height (src_height),
    .dst_width  (dst_width),
    .dst_height (dst_height),
    .req_type   (req_type),
    .src_index  (src_index),
    .pixel_red  (pixel_red),
    .pixel_green(pixel_green),
    .pixel_blue (pixel_blue),
    .dst_x      (dst_x),
    .dst_y      (dst_y),
    .dims       (dims),
    .item       (item)
  );

  // decouples accept from the back end's result slot reservation
  nnis_midq u_midq (
    .clk    (clk),
    .rst    (rst),
    .wr     (push && !full),
    .wr_item(item),
    .full   (full),
    .rd     (mq_pop),
    .head   (head),
    .empty  (mq_empty)
  );

  // back: division, address, frame store, result queue
  nnis_back u_back (
    .clk     (clk),
    .rst     (rst),
    .dims    (dims),
    .head    (head),
    .mq_empty(mq_empty),
    .mq_pop  (mq_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  assign out_red      = result.pixel[23:16];
  assign out_green    = result.pixel[15:8];
  assign out_blue     = result.pixel[7:0];
  assign src_col      = result.col;
  assign src_row      = result.row;
  assign out_of_range = result.oor;

endmodule

/* src/nnis_checker.sv */
// ----------------------------------------------------------------------------
// nnis_checker
// port level checks of the nearest neighbor image scaler
// ----------------------------------------------------------------------------
module nnis_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] src_col,
  input logic [7:0] src_row,
  input logic       out_of_range
);

  // nothing pending and room for items right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not idle after reset");

  // a fetch outside the target returns zeros
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_of_range) |->
      (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0 &&
       src_col == 8'd0 && src_row == 8'd0))
    else $error("out of range result not zero");

  // a waiting result is not dropped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result lost");

  // a waiting result holds its red, column, row and range flag
  a_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(out_red) && $stable(src_col) &&
                          $stable(src_row) && $stable(out_of_range)))
    else $error("result changed while waiting");

endmodule

bind nearest_neighbor_image_scaler nnis_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_red     (out_red),
  .out_green   (out_green),
  .out_blue    (out_blue),
  .src_col     (src_col),
  .src_row     (src_row),
  .out_of_range(out_of_range)
);

/* test/tb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checker
// watches the item and result channels of the scaler, predicts every fetch
// result from a private frame store and compares it field by field
// ----------------------------------------------------------------------------
module tb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        push,
  input  logic        full,
  input  logic        req_type,
  input  logic [15:0] src_index,
  input  logic [7:0]  pixel_red,
  input  logic [7:0]  pixel_green,
  input  logic [7:0]  pixel_blue,
  input  logic [11:0] dst_x,
  input  logic [11:0] dst_y,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  src_col,
  input  logic [7:0]  src_row,
  input  logic        out_of_range,
  output int          err_total,
  output int          pending
);
  import nnis_pkg::*;

  typedef struct packed {
    logic [23:0] pixel;
    logic [7:0]  col;
    logic [7:0]  row;
    logic        oor;
  } pixel_result_t;

  logic [SW_W-1:0] sw_reg, sh_reg;
  logic [DW_W-1:0] dw_reg, dh_reg;
  logic [23:0] image_mem [STORE_DEPTH];
  pixel_result_t scaled_q[$];

  assign pending = scaled_q.size();

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  // nearest source coordinate, clamped to the last column or row
  function automatic int unsigned map_coord(int unsigned d, int unsigned s,
                                            int unsigned dd);
    int unsigned p;
    p = (d * s) / dd;
    if (p >= s) p = s - 1;
    return p;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_total++;
  endtask

  always @(posedge clk) begin
    int unsigned sw, sh, dw, dh, col, row;
    pixel_result_t r, e;
    if (rst) begin
      sw_reg <= 256; sh_reg <= 256; dw_reg <= 256; dh_reg <= 256;
      scaled_q.delete();
      err_total = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SRC_WIDTH:  sw_reg <= pwdata[SW_W-1:0];
          REG_SRC_HEIGHT: sh_reg <= pwdata[SW_W-1:0];
          REG_DST_WIDTH:  dw_reg <= pwdata[DW_W-1:0];
          REG_DST_HEIGHT: dh_reg <= pwdata[DW_W-1:0];
          default: ;
        endcase
      end
      sw = clamp_dim(sw_reg, MAX_SRC_WIDTH);
      sh = clamp_dim(sh_reg, MAX_SRC_HEIGHT);
      dw = clamp_dim(dw_reg, MAX_DST_DIM);
      dh = clamp_dim(dh_reg, MAX_DST_DIM);
      if (push && !full) begin
        if (!req_type) begin
          if (src_index < sw * sh)
            image_mem[src_index] = {pixel_red, pixel_green, pixel_blue};
        end else begin
          e = '0;
          if (dst_x >= dw || dst_y >= dh) e.oor = 1'b1;
          else begin
            col = map_coord(dst_x, sw, dw);
            row = map_coord(dst_y, sh, dh);
            e.pixel = image_mem[row * sw + col];
            e.col = col;
            e.row = row;
          end
          scaled_q.push_back(e);
        end
      end
      if (pop && !empty) begin
        r = {out_red, out_green, out_blue, src_col, src_row, out_of_range};
        if (scaled_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          e = scaled_q.pop_front();
          if (r.pixel[23:16] !== e.pixel[23:16])
            report("out_red", r.pixel[23:16], e.pixel[23:16]);
          if (r.pixel[15:8] !== e.pixel[15:8])
            report("out_green", r.pixel[15:8], e.pixel[15:8]);
          if (r.pixel[7:0] !== e.pixel[7:0])
            report("out_blue", r.pixel[7:0], e.pixel[7:0]);
          if (r.col !== e.col) report("src_col", r.col, e.col);
          if (r.row !== e.row) report("src_row", r.row, e.row);
          if (r.oor !== e.oor) report("out_of_range", r.oor, e.oor);
        end
      end
    end
  end
endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the nearest neighbor image scaler
// ----------------------------------------------------------------------------
// each phase sets the four sizes, loads the whole source image (so no fetch
// can hit an unwritten pixel), then mixes fetches with stray loads. phases
// step through extreme and random sizes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import nnis_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0, full;
  logic req_type = 1'b0;
  logic [15:0] src_index = '0;
  logic [7:0] pixel_red = '0, pixel_green = '0, pixel_blue = '0;
  logic [11:0] dst_x = '0, dst_y = '0;
  logic empty, pop = 1'b0;
  logic [7:0] out_red, out_green, out_blue, src_col, src_row;
  logic out_of_range;
  int err_total, pending;
  int cycle_count = 0;
  // receiver modes: 0 random idling, 1 always ready, 2 long hold-off
  int sink_mode = 0;
  bit calm_sender = 1'b0;

  always #5 clk = ~clk;

  nearest_neighbor_image_scaler dut (.*);
  tb_checker chk (.*);

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random idling, always ready, or a counted hold-off
  always @(posedge clk) begin
    int k;
    if (sink_mode == 2) begin
      pop <= 1'b0;
      for (k = 0; k < 300; k++) @(posedge clk);
      sink_mode = 0;
    end else if (sink_mode == 1) pop <= 1'b1;
    else pop <= ($urandom_range(99) >= 12);
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // one item, held until the block takes it
  task automatic send_item(logic rt, logic [15:0] idx, logic [23:0] px,
                           logic [11:0] x, logic [11:0] y);
    if (!calm_sender)
      while ($urandom_range(99) < 12) begin
        push <= 1'b0;
        @(posedge clk);
      end
    push <= 1'b1; req_type <= rt; src_index <= idx;
    {pixel_red, pixel_green, pixel_blue} <= px;
    dst_x <= x; dst_y <= y;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain;
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // set sizes, fill the image, then fetch
  task automatic run_phase(int sw, int sh, int dw, int dh, int fetches);
    int i, esw, esh, edw, edh;
    esw = (sw == 0) ? 1 : (sw > 256 ? 256 : sw);
    esh = (sh == 0) ? 1 : (sh > 256 ? 256 : sh);
    edw = (dw == 0) ? 1 : (dw > 4096 ? 4096 : dw);
    edh = (dh == 0) ? 1 : (dh > 4096 ? 4096 : dh);
    drain();
    reg_write(REG_SRC_WIDTH, sw);
    reg_write(REG_SRC_HEIGHT, sh);
    reg_write(REG_DST_WIDTH, dw);
    reg_write(REG_DST_HEIGHT, dh);
    for (i = 0; i < esw * esh; i++) send_item(1'b0, i, $urandom, 0, 0);
    for (i = 0; i < fetches; i++) begin
      case ($urandom_range(9))
        0: send_item(1'b0, $urandom, $urandom, $urandom, $urandom);
        1: send_item(1'b1, $urandom, $urandom, $urandom, $urandom);
        2: send_item(1'b1, $urandom, $urandom, edw - 1, edh - 1);
        default: send_item(1'b1, $urandom, $urandom,
                           $urandom_range(edw - 1), $urandom_range(edh - 1));
      endcase
    end
  endtask

  initial begin
    int i;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed: tiny images, corners, out of range loads and fetches
    run_phase(2, 2, 4096, 4096, 0);
    send_item(1'b0, 16'hFFFF, 24'hFFFFFF, 0, 0);
    send_item(1'b0, 4, 24'h123456, 0, 0);
    send_item(1'b1, 0, 0, 0, 0);
    send_item(1'b1, 0, 0, 4095, 4095);
    send_item(1'b1, 0, 0, 2048, 0);
    send_item(1'b1, 0, 0, 0, 2048);
    run_phase(1, 1, 1, 1, 0);
    send_item(1'b1, 0, 0, 0, 0);
    send_item(1'b1, 0, 0, 1, 0);
    send_item(1'b1, 0, 0, 0, 1);
    send_item(1'b1, 0, 0, 12'hFFF, 12'hFFF);
    // register values out of range: zero and above the maximum
    run_phase(0, 511, 0, 8191, 8);
    run_phase(3, 5, 7, 3, 40);
    // long stretch with no idling
    sink_mode = 1; calm_sender = 1'b1;
    run_phase(8, 6, 4096, 1, 200);
    calm_sender = 1'b0; sink_mode = 0;
    // receiver holds off while the sender keeps pushing
    drain();
    sink_mode = 2;
    for (i = 0; i < 60; i++) send_item(1'b1, 0, 0, $urandom, $urandom);
    for (i = 0; i < 4; i++)
      run_phase($urandom_range(1, 12), $urandom_range(1, 12),
                $urandom_range(1, 4096), $urandom_range(1, 4096), 60);
    drain();
    if (err_total == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* nearest_neighbor_image_scaler.f */
src/nnis_pkg.sv
src/nnis_ram.sv
src/nnis_front.sv
src/nnis_midq.sv
src/nnis_back.sv
src/nearest_neighbor_image_scaler.sv
src/nnis_checker.sv
test/tb_checker.sv
test/tb_top.sv
